### hdl/merge_sort_comparison_count_assert.svh
`ifndef MERGE_SORT_COMPARISON_COUNT_ASSERT_SVH
`define MERGE_SORT_COMPARISON_COUNT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSCC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSCC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define MSCC_ASSERT(label, clk, rst_n, prop, msg)
`define MSCC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

### hdl/mscc_pkg.sv
`timescale 1ns / 1ps
package mscc_pkg;
    localparam int MAX_ITEMS = 64;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = AW + 1;
    localparam int KW = 32;
    localparam int NW = 9;
    // marked parent plus two children per level
    localparam int SD = 2 * AW + 2;
    localparam int SPW = $clog2(SD);

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [11:0] {
        S_LOAD  = 12'b000000000001,
        S_POP   = 12'b000000000010,
        S_RD    = 12'b000000000100,
        S_CMP   = 12'b000000001000,
        S_CPW   = 12'b000000010000,
        S_BACK  = 12'b000000100000,
        S_BKW   = 12'b000001000000,
        S_ERD   = 12'b000010000000,
        S_EOUT  = 12'b000100000000,
        S_MRD   = 12'b001000000000,
        S_MRD2  = 12'b010000000000,
        S_ELOAD = 12'b100000000000
    } state_t;

    typedef struct packed {
        addr_t lo;
        addr_t hi;
        logic  merged;
    } frame_t;
endpackage

### hdl/merge_sort_comparison_count.sv
`timescale 1ns / 1ps
// Merge sort with comparison count.
// Input stream s_axis: tdata = value[31:0]; tlast marks the final word of a set.
// Words are stored one per cycle while loading. Beyond 64 words they are
// dropped and the overflow flag is set. After the last word the set is sorted
// by top-down merge sort in two synchronous RAMs (keys, scratch): each merge
// step reads, compares and writes one key to scratch, and each merged run is
// then copied back to the key RAM.
// Output stream m_axis: tdata = value[31:0], comparisons[40:32],
// overflow[41], zero fill to 48 bits; tlast on the final sorted key.
// Each output key is read from the key RAM, then registered; the output register holds
// while tready is low, so a stalled receiver just stalls the block.
// No input is accepted from the last word until the final key is taken.
// Reset (rst_n low, asynchronous) clears the counts and returns to loading;
// RAM contents are not cleared.
module merge_sort_comparison_count
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value[31:0], comparisons[40:32], overflow[41]
    output logic        m_axis_tlast
);
    mscc_pkg::state_t state_reg, state_next;
    mscc_pkg::cnt_t cnt_reg, cnt_next;
    logic [mscc_pkg::NW-1:0] cmp_reg, cmp_next;
    logic ovf_reg, ovf_next;
    mscc_pkg::frame_t stk_reg [mscc_pkg::SD];
    logic [mscc_pkg::SPW:0] sp_reg, sp_next;
    mscc_pkg::addr_t lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    mscc_pkg::cnt_t i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [31:0] od_reg, od_next;
    logic ol_reg, ol_next, ov_reg, ov_next;

    logic ka_we, sc_we;
    mscc_pkg::addr_t ka_wa, ka_ra, ka_rb, sc_wa, sc_ra;
    logic [31:0] ka_wd, sc_wd, ka_qa, ka_qb, sc_qa, sc_qb;
    logic push, pop;
    mscc_pkg::frame_t push_f, top_f;
    logic [mscc_pkg::AW:0] lohi;
    mscc_pkg::addr_t mid_c;
    logic acc_in;

    mscc_ram u_keys (.clk(clk), .we(ka_we), .waddr(ka_wa), .wdata(ka_wd),
        .raddr_a(ka_ra), .rdata_a(ka_qa), .raddr_b(ka_rb), .rdata_b(ka_qb));
    mscc_ram u_scr (.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd),
        .raddr_a(sc_ra), .rdata_a(sc_qa), .raddr_b(sc_ra), .rdata_b(sc_qb));

    assign s_axis_tready = (state_reg == mscc_pkg::S_LOAD);
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {6'd0, ovf_reg, cmp_reg, od_reg};
    assign m_axis_tlast = ol_reg;
    assign top_f = stk_reg[sp_reg[mscc_pkg::SPW-1:0] - 1'b1];
    assign lohi = {1'b0, top_f.lo} + {1'b0, top_f.hi};
    assign mid_c = lohi[mscc_pkg::AW:1];

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; cmp_next = cmp_reg; ovf_next = ovf_reg;
        sp_next = sp_reg; lo_next = lo_reg; mid_next = mid_reg; hi_next = hi_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg;
        od_next = od_reg; ol_next = ol_reg; ov_next = ov_reg;
        ka_we = 1'b0; ka_wa = cnt_reg[mscc_pkg::AW-1:0]; ka_wd = s_axis_tdata;
        ka_ra = i_reg[mscc_pkg::AW-1:0]; ka_rb = j_reg[mscc_pkg::AW-1:0];
        sc_we = 1'b0; sc_wa = k_reg[mscc_pkg::AW-1:0]; sc_wd = ka_qa;
        sc_ra = k_reg[mscc_pkg::AW-1:0];
        push = 1'b0; pop = 1'b0; push_f = '0;
        if (m_axis_tvalid && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            mscc_pkg::S_LOAD:
            begin
                if (acc_in)
                begin
                    if (cnt_reg < mscc_pkg::cnt_t'(mscc_pkg::MAX_ITEMS))
                    begin
                        ka_we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        cmp_next = '0;
                        push = 1'b1;
                        push_f.lo = '0;
                        push_f.hi = mscc_pkg::addr_t'(cnt_next - 1'b1);
                        push_f.merged = 1'b0;
                        sp_next = {{mscc_pkg::SPW{1'b0}}, 1'b1};
                        state_next = mscc_pkg::S_POP;
                    end
                end
            end
            mscc_pkg::S_POP:
            begin
                if (sp_reg == 0)
                begin
                    k_next = '0;
                    state_next = mscc_pkg::S_ERD;
                end
                else if (top_f.lo >= top_f.hi)
                begin
                    pop = 1'b1; sp_next = sp_reg - 1'b1;
                end
                else if (!top_f.merged)
                begin
                    // mark, then push right and left halves
                    sp_next = sp_reg + 2'd2;
                end
                else
                begin
                    pop = 1'b1; sp_next = sp_reg - 1'b1;
                    lo_next = top_f.lo; hi_next = top_f.hi; mid_next = mid_c;
                    i_next = {1'b0, top_f.lo};
                    j_next = {1'b0, mid_c} + 1'b1;
                    k_next = {1'b0, top_f.lo};
                    state_next = mscc_pkg::S_RD;
                end
            end
            mscc_pkg::S_RD:
            begin
                if (k_reg > {1'b0, hi_reg})
                begin
                    k_next = {1'b0, lo_reg};
                    state_next = mscc_pkg::S_BACK;
                end
                else
                begin
                    state_next = mscc_pkg::S_CMP;
                end
            end
            mscc_pkg::S_CMP:
            begin
                sc_we = 1'b1;
                if (i_reg <= {1'b0, mid_reg} && j_reg <= {1'b0, hi_reg})
                begin
                    cmp_next = cmp_reg + 1'b1;
                    if ($signed(ka_qa) < $signed(ka_qb))
                    begin
                        sc_wd = ka_qa; i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        sc_wd = ka_qb; j_next = j_reg + 1'b1;
                    end
                end
                else if (i_reg <= {1'b0, mid_reg})
                begin
                    sc_wd = ka_qa; i_next = i_reg + 1'b1;
                end
                else
                begin
                    sc_wd = ka_qb; j_next = j_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                state_next = mscc_pkg::S_RD;
            end
            mscc_pkg::S_BACK:
            begin
                if (k_reg > {1'b0, hi_reg})
                begin
                    state_next = mscc_pkg::S_POP;
                end
                else
                begin
                    state_next = mscc_pkg::S_BKW;
                end
            end
            mscc_pkg::S_BKW:
            begin
                ka_we = 1'b1; ka_wa = k_reg[mscc_pkg::AW-1:0]; ka_wd = sc_qa;
                k_next = k_reg + 1'b1;
                state_next = mscc_pkg::S_BACK;
            end
            mscc_pkg::S_ERD:
            begin
                ka_ra = k_reg[mscc_pkg::AW-1:0];
                if (!ov_reg || m_axis_tready)
                begin
                    state_next = mscc_pkg::S_EOUT;
                end
            end
            mscc_pkg::S_EOUT:
            begin
                od_next = ka_qa; ov_next = 1'b1;
                ol_next = (k_reg + 1'b1 == cnt_reg);
                k_next = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 == cnt_reg) ? mscc_pkg::S_ELOAD
                                                       : mscc_pkg::S_ERD;
            end
            mscc_pkg::S_ELOAD:
            begin
                if (m_axis_tready)
                begin
                    cnt_next = '0; ovf_next = 1'b0;
                    state_next = mscc_pkg::S_MRD;
                end
            end
            mscc_pkg::S_MRD:
            begin
                cmp_next = '0;
                state_next = mscc_pkg::S_MRD2;
            end
            mscc_pkg::S_MRD2:
            begin
                state_next = mscc_pkg::S_LOAD;
            end
            default:
            begin
                state_next = mscc_pkg::S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_reg[0] <= push_f;
        end
        else if (state_reg == mscc_pkg::S_POP && sp_reg != 0 && !pop)
        begin
            stk_reg[sp_reg[mscc_pkg::SPW-1:0] - 1'b1] <=
                '{lo: top_f.lo, hi: top_f.hi, merged: 1'b1};
            stk_reg[sp_reg[mscc_pkg::SPW-1:0]] <=
                '{lo: mid_c + 1'b1, hi: top_f.hi, merged: 1'b0};
            stk_reg[sp_reg[mscc_pkg::SPW-1:0] + 1'b1] <=
                '{lo: top_f.lo, hi: mid_c, merged: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mscc_pkg::S_LOAD;
            cnt_reg <= '0; cmp_reg <= '0; ovf_reg <= 1'b0; sp_reg <= '0;
            ov_reg <= 1'b0; ol_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next; cmp_reg <= cmp_next; ovf_reg <= ovf_next;
            sp_reg <= sp_next; ov_reg <= ov_next; ol_reg <= ol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; mid_reg <= mid_next; hi_reg <= hi_next;
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; od_reg <= od_next;
    end

`include "merge_sort_comparison_count_assert.svh"
    `MSCC_ASSERT(a_cnt_cap, clk, rst_n, cnt_reg <= mscc_pkg::cnt_t'(mscc_pkg::MAX_ITEMS), "count")
    `MSCC_ASSERT(a_no_in_busy, clk, rst_n, m_axis_tvalid |-> !s_axis_tready, "busy")
    `MSCC_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "hold")
    `MSCC_ASSERT(a_sp, clk, rst_n, sp_reg <= mscc_pkg::SD, "stack")
endmodule

### hdl/mscc_ram.sv
`timescale 1ns / 1ps
module mscc_ram
(
    input  logic                    clk,
    input  logic                    we,
    input  mscc_pkg::addr_t         waddr,
    input  logic [mscc_pkg::KW-1:0] wdata,
    input  mscc_pkg::addr_t         raddr_a,
    output logic [mscc_pkg::KW-1:0] rdata_a,
    input  mscc_pkg::addr_t         raddr_b,
    output logic [mscc_pkg::KW-1:0] rdata_b
);
    logic [mscc_pkg::KW-1:0] mem [mscc_pkg::MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    typedef struct {
        logic [31:0] value;
        logic        last;
        logic [8:0]  comparisons;
        logic        overflow;
    } sorted_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    sorted_word_t sorted_q[$];
    logic [31:0]  set_keys[$];
    logic         set_overflow;
    int           error_count;
    int           idle_cycles;
    int           stall_left;
    bit           done;

    localparam int WATCHDOG = 200000;

    merge_sort_comparison_count dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // top-down merge sort, right key wins ties; counts merge-loop compares
    function automatic int merge_sort_count(ref logic [31:0] keys[$], input int lo, input int hi);
        logic [31:0] merged[$];
        int mid;
        int i;
        int j;
        int compares;
        if (lo >= hi)
            return 0;
        mid = (lo + hi) / 2;
        compares = merge_sort_count(keys, lo, mid);
        compares += merge_sort_count(keys, mid + 1, hi);
        i = lo;
        j = mid + 1;
        while (i <= mid && j <= hi)
        begin
            compares++;
            if ($signed(keys[i]) < $signed(keys[j]))
            begin
                merged.push_back(keys[i]);
                i++;
            end
            else
            begin
                merged.push_back(keys[j]);
                j++;
            end
        end
        while (i <= mid)
        begin
            merged.push_back(keys[i]);
            i++;
        end
        while (j <= hi)
        begin
            merged.push_back(keys[j]);
            j++;
        end
        foreach (merged[n])
            keys[lo + n] = merged[n];
        return compares;
    endfunction

    function automatic void predict_word(logic [31:0] value, logic last);
        int compares;
        sorted_word_t w;
        if (set_keys.size() < mscc_pkg::MAX_ITEMS)
            set_keys.push_back(value);
        else
            set_overflow = 1'b1;
        if (!last)
            return;
        compares = merge_sort_count(set_keys, 0, set_keys.size() - 1);
        foreach (set_keys[k])
        begin
            w.value = set_keys[k];
            w.last = (k == set_keys.size() - 1);
            w.comparisons = compares[8:0];
            w.overflow = set_overflow;
            sorted_q.push_back(w);
        end
        set_keys.delete();
        set_overflow = 1'b0;
    endfunction

    task automatic send_word(logic [31:0] value, logic last);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_word(value, last);
    endtask

    task automatic send_set(int count, int mode);
        logic [31:0] v;
        for (int n = 0; n < count; n++)
        begin
            case (mode)
                0: v = $urandom();
                1: v = $urandom_range(0, 3) - 2;
                default: v = (n % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            endcase
            send_word(v, n == count - 1);
        end
    endtask

    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sorted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        send_set(6, 2);
        send_set(5, 1);
    endtask

    task automatic test_overflow();
        send_set(67, 0);
        send_set(64, 1);
        send_set(65, 0);
    endtask

    task automatic test_random_sets();
        int size;
        for (int s = 0; s < 5; s++)
        begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
            send_set(size, $urandom_range(0, 3) == 0);
            if (s == 2)
                drain_wait();
        end
    endtask

    always @(posedge clk)
    begin
        int gap;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                gap = random_gap();
                if (gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left <= gap - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sorted_q.size() == 0)
            begin
                $error("unexpected word value %h", m_axis_tdata[31:0]);
                error_count++;
            end
            else
            begin
                w = sorted_q.pop_front();
                if (m_axis_tdata[31:0] !== w.value)
                begin
                    $error("value: expected %h, got %h", w.value, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tlast !== w.last)
                begin
                    $error("last: expected %b, got %b", w.last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tdata[40:32] !== w.comparisons)
                begin
                    $error("comparisons: expected %0d, got %0d", w.comparisons,
                           m_axis_tdata[40:32]);
                    error_count++;
                end
                if (m_axis_tdata[41] !== w.overflow)
                begin
                    $error("overflow: expected %b, got %b", w.overflow, m_axis_tdata[41]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        done = 1'b0;
        set_overflow = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_overflow();
        test_random_sets();
        drain_wait();
        done = 1'b1;
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/mscc_pkg.sv
hdl/mscc_ram.sv
hdl/merge_sort_comparison_count.sv
tb/testbench.sv
